### rtl/core/chte_pkg.sv
// Shared types and constants for the chained hash table engine.
`timescale 1ns / 1ps

package chte_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int POOL_DEPTH  = 64;
  localparam int HASH_W      = 30;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = $clog2(POOL_DEPTH);
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int LINK_W      = IDX_W + 1;
  localparam int TOP_W       = IDX_W + 1;
  localparam int CNT_W       = 8;
  localparam int DIVIDEND_W  = HASH_W;
  localparam int STEP_W      = $clog2(DIVIDEND_W + 1);
  localparam int RED_W       = 39;
  localparam int RED_SH_W    = 4;
  localparam int RED_HASH_SH = 8;
  localparam int RED_POW_SH  = 4;

  localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000009;
  localparam logic [8:0]        CHAR_OFFSET = 9'd96;
  localparam logic [LINK_W-1:0] NO_LINK     = LINK_W'(POOL_DEPTH);

  // 2^64 mod HASH_MOD, and that plus 256 moduli to lift a negative sum above zero.
  localparam logic [63:0] WRAP_64 =
    (64'hFFFF_FFFF_FFFF_FFFF % 64'(HASH_MOD)) + 64'd1;
  localparam logic [RED_W-1:0] WRAP_FIX =
    RED_W'(WRAP_64 + (64'(HASH_MOD) << RED_HASH_SH));

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_ADD    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_ABSENT = 2'd1,
    FAIL_FULL   = 2'd2
  } fail_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_HMOD, ST_PMOD, ST_BKT, ST_RRD, ST_RCHK,
    ST_WALK, ST_NCHK, ST_PULLRD, ST_PULL, ST_FRD, ST_FGOT, ST_FLINK, ST_RESP
  } state_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
    logic [LINK_W-1:0]  link;
  } entry_t;

endpackage

### rtl/core/chained_hash_table_engine_unit.sv
// Top level of the chained hash table engine: sequencer, shared modulo unit and tables.
`timescale 1ns / 1ps

// Key character items fold into a rolling hash; each one passes through one
// multiply, one add, then a constant compare-and-subtract reduction of 9 steps
// for the hash and 5 for the power before the next item is accepted.
// A command runs the bucket modulo (a restoring division over the hash bits),
// then root read, check and result. Each chain node visited adds a node read
// and check, reaching the chain end adds a walk step, linking in a new node
// adds a free-stack read, node write and link, and pulling a successor into the
// root adds a node read and root write, since root, node and free-stack
// memories have registered reads. The block takes one item at a time. A result
// waits in the output register while character items keep being accepted.
// Writing bucket_count clears the table directly; there is no clearing pass.
module chained_hash_table_engine_unit
  import chte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [7:0]  key_char,
  input  logic signed [31:0] entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               success,
  output logic signed [31:0] read_value,
  output logic [1:0]         fail_code,
  output logic [7:0]         entry_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  state_t state, state_next;

  logic [HASH_W-1:0]     hash_accum, hash_accum_next;
  logic [HASH_W-1:0]     power_accum, power_accum_next;
  logic [6:0]            bucket_count, bucket_count_next;
  logic [MAX_BUCKETS-1:0] root_used, root_used_next;
  logic [TOP_W-1:0]      free_top, free_top_next;
  logic [TOP_W-1:0]      min_top, min_top_next;
  logic [CNT_W-1:0]      entry_count, entry_count_next;

  logic [1:0]            cmd_op, cmd_op_next;
  logic [VALUE_W-1:0]    cmd_val, cmd_val_next;
  logic [HASH_W-1:0]     cmd_hash, cmd_hash_next;
  logic signed [7:0]     ch, ch_next;
  logic signed [39:0]    prod, prod_next;
  logic [BKT_W-1:0]      bkt, bkt_next;
  logic [LINK_W-1:0]     cur, cur_next;
  logic                  prev_valid, prev_valid_next;
  logic [IDX_W-1:0]      prev, prev_next;
  logic [HASH_W-1:0]     prev_hash, prev_hash_next;
  logic [VALUE_W-1:0]    prev_val, prev_val_next;
  logic [IDX_W-1:0]      new_nd, new_nd_next;

  logic                  res_ok, res_ok_next;
  logic [VALUE_W-1:0]    res_rv, res_rv_next;
  logic [1:0]            res_fc, res_fc_next;
  logic                  out_valid_next;
  logic                  success_next;
  logic [VALUE_W-1:0]    read_value_next;
  logic [1:0]            fail_code_next;
  logic [CNT_W-1:0]      entry_total_next;

  // Shared restoring modulo unit, one dividend bit per cycle.
  logic [DIVIDEND_W-1:0] mod_dvd, mod_dvd_next;
  logic [HASH_W-1:0]     mod_div, mod_div_next;
  logic [HASH_W-1:0]     mod_rem, mod_rem_next;
  logic [STEP_W-1:0]     mod_cnt, mod_cnt_next;
  logic [HASH_W:0]       mod_trial;
  logic [HASH_W:0]       mod_diff;

  // Reduction by the hash modulus: subtract the modulus shifted left by red_sh when it fits.
  logic [RED_W-1:0]      red, red_next;
  logic [RED_SH_W-1:0]   red_sh, red_sh_next;
  logic [RED_W-1:0]      red_cmp;
  logic [RED_W-1:0]      red_step;

  entry_t root_mem [MAX_BUCKETS];
  entry_t node_mem [POOL_DEPTH];
  logic [IDX_W-1:0] stack_mem [POOL_DEPTH];
  entry_t root_q, node_q;
  logic [IDX_W-1:0] stack_q;

  logic              root_we;
  entry_t            root_wd;
  logic              node_we;
  logic [IDX_W-1:0]  node_wa;
  entry_t            node_wd;
  logic              stack_we;
  logic [IDX_W-1:0]  stack_wd;

  logic [IDX_W-1:0]  top_m1;
  logic [IDX_W-1:0]  pop_nd;
  logic [8:0]        d9;
  logic [40:0]       sum_t;
  logic [40:0]       sum_fix;
  logic [34:0]       pow31;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign top_m1    = IDX_W'(free_top - TOP_W'(1));
  assign pop_nd    = ({1'b0, top_m1} >= min_top) ? stack_q : top_m1;
  assign d9        = {ch[7], ch} - CHAR_OFFSET;
  assign sum_t     = {prod[39], prod} + {11'b0, hash_accum};
  assign sum_fix   = sum_t + {2'b0, WRAP_FIX};
  assign pow31     = {power_accum, 5'b0} - {5'b0, power_accum};
  assign mod_trial = {mod_rem, mod_dvd[DIVIDEND_W-1]};
  assign mod_diff  = mod_trial - {1'b0, mod_div};
  assign red_cmp   = {{(RED_W-HASH_W){1'b0}}, HASH_MOD} << red_sh;
  assign red_step  = (red >= red_cmp) ? red - red_cmp : red;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash_accum   <= '0;
      power_accum  <= HASH_W'(1);
      bucket_count <= 7'd16;
      root_used    <= '0;
      free_top     <= TOP_W'(POOL_DEPTH);
      min_top      <= TOP_W'(POOL_DEPTH);
      entry_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      hash_accum   <= hash_accum_next;
      power_accum  <= power_accum_next;
      bucket_count <= bucket_count_next;
      root_used    <= root_used_next;
      free_top     <= free_top_next;
      min_top      <= min_top_next;
      entry_count  <= entry_count_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_op      <= cmd_op_next;
    cmd_val     <= cmd_val_next;
    cmd_hash    <= cmd_hash_next;
    ch          <= ch_next;
    prod        <= prod_next;
    bkt         <= bkt_next;
    cur         <= cur_next;
    prev_valid  <= prev_valid_next;
    prev        <= prev_next;
    prev_hash   <= prev_hash_next;
    prev_val    <= prev_val_next;
    new_nd      <= new_nd_next;
    res_ok      <= res_ok_next;
    res_rv      <= res_rv_next;
    res_fc      <= res_fc_next;
    success     <= success_next;
    read_value  <= read_value_next;
    fail_code   <= fail_code_next;
    entry_total <= entry_total_next;
    mod_dvd     <= mod_dvd_next;
    mod_div     <= mod_div_next;
    mod_rem     <= mod_rem_next;
    mod_cnt     <= mod_cnt_next;
    red         <= red_next;
    red_sh      <= red_sh_next;
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[bkt] <= root_wd;
    end
    root_q <= root_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[cur[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[free_top[IDX_W-1:0]] <= stack_wd;
    end
    stack_q <= stack_mem[top_m1];
  end

  always_comb begin
    state_next        = state;
    hash_accum_next   = hash_accum;
    power_accum_next  = power_accum;
    bucket_count_next = bucket_count;
    root_used_next    = root_used;
    free_top_next     = free_top;
    min_top_next      = min_top;
    entry_count_next  = entry_count;
    cmd_op_next       = cmd_op;
    cmd_val_next      = cmd_val;
    cmd_hash_next     = cmd_hash;
    ch_next           = ch;
    prod_next         = prod;
    bkt_next          = bkt;
    cur_next          = cur;
    prev_valid_next   = prev_valid;
    prev_next         = prev;
    prev_hash_next    = prev_hash;
    prev_val_next     = prev_val;
    new_nd_next       = new_nd;
    res_ok_next       = res_ok;
    res_rv_next       = res_rv;
    res_fc_next       = res_fc;
    out_valid_next    = out_valid && !out_ready;
    success_next      = success;
    read_value_next   = read_value;
    fail_code_next    = fail_code;
    entry_total_next  = entry_total;
    mod_dvd_next      = mod_dvd;
    mod_div_next      = mod_div;
    mod_rem_next      = mod_rem;
    mod_cnt_next      = mod_cnt;
    red_next          = red;
    red_sh_next       = red_sh;
    root_we           = 1'b0;
    root_wd           = root_q;
    node_we           = 1'b0;
    node_wa           = prev;
    node_wd           = node_q;
    stack_we          = 1'b0;
    stack_wd          = cur[IDX_W-1:0];

    if (state == ST_BKT && mod_cnt != '0) begin
      mod_rem_next = (mod_trial >= {1'b0, mod_div}) ? mod_diff[HASH_W-1:0]
                                                     : mod_trial[HASH_W-1:0];
      mod_dvd_next = {mod_dvd[DIVIDEND_W-2:0], 1'b0};
      mod_cnt_next = mod_cnt - STEP_W'(1);
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_op_next  = operation;
          cmd_val_next = entry_value;
          ch_next      = key_char;
          if (operation == OP_CHAR) begin
            if (key_char != 8'sd0) begin
              state_next = ST_MUL;
            end
          end else begin
            cmd_hash_next    = hash_accum;
            hash_accum_next  = '0;
            power_accum_next = HASH_W'(1);
            mod_dvd_next     = hash_accum;
            mod_div_next     = {{(HASH_W-7){1'b0}}, bucket_count};
            mod_rem_next     = '0;
            mod_cnt_next     = STEP_W'(DIVIDEND_W);
            state_next       = ST_BKT;
          end
        end
      end
      ST_MUL: begin
        prod_next  = $signed(d9) * $signed({1'b0, power_accum});
        state_next = ST_ADD;
      end
      ST_ADD: begin
        // A negative sum stands for itself plus 2^64.
        red_next    = sum_t[40] ? sum_fix[RED_W-1:0] : sum_t[RED_W-1:0];
        red_sh_next = RED_SH_W'(RED_HASH_SH);
        state_next  = ST_HMOD;
      end
      ST_HMOD: begin
        red_next = red_step;
        if (red_sh == '0) begin
          hash_accum_next = red_step[HASH_W-1:0];
          red_next        = {{(RED_W-35){1'b0}}, pow31};
          red_sh_next     = RED_SH_W'(RED_POW_SH);
          state_next      = ST_PMOD;
        end else begin
          red_sh_next = red_sh - RED_SH_W'(1);
        end
      end
      ST_PMOD: begin
        red_next = red_step;
        if (red_sh == '0) begin
          power_accum_next = red_step[HASH_W-1:0];
          state_next       = ST_IDLE;
        end else begin
          red_sh_next = red_sh - RED_SH_W'(1);
        end
      end
      ST_BKT: begin
        if (mod_cnt == '0) begin
          bkt_next   = mod_rem[BKT_W-1:0];
          state_next = ST_RRD;
        end
      end
      ST_RRD: begin
        state_next = ST_RCHK;
      end
      ST_RCHK: begin
        res_ok_next     = 1'b0;
        res_rv_next     = '0;
        res_fc_next     = FAIL_ABSENT;
        prev_valid_next = 1'b0;
        state_next      = ST_RESP;
        if (!root_used[bkt]) begin
          if (cmd_op == OP_ADD) begin
            root_we              = 1'b1;
            root_wd              = '{hash: cmd_hash, value: cmd_val, link: NO_LINK};
            root_used_next[bkt]  = 1'b1;
            entry_count_next     = entry_count + CNT_W'(1);
            res_ok_next          = 1'b1;
            res_fc_next          = FAIL_NONE;
          end
        end else if (root_q.hash == cmd_hash) begin
          if (cmd_op == OP_LOOKUP) begin
            res_ok_next = 1'b1;
            res_fc_next = FAIL_NONE;
            res_rv_next = root_q.value;
          end else if (cmd_op == OP_REMOVE) begin
            if (root_q.link < NO_LINK) begin
              cur_next   = root_q.link;
              state_next = ST_PULLRD;
            end else begin
              root_used_next[bkt] = 1'b0;
              entry_count_next    = entry_count - CNT_W'(1);
              res_ok_next         = 1'b1;
              res_fc_next         = FAIL_NONE;
            end
          end
        end else begin
          cur_next   = root_q.link;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cur >= NO_LINK) begin
          state_next = ST_RESP;
          if (cmd_op == OP_ADD) begin
            if (free_top == '0) begin
              res_fc_next = FAIL_FULL;
            end else begin
              state_next = ST_FRD;
            end
          end
        end else begin
          state_next = ST_NCHK;
        end
      end
      ST_NCHK: begin
        if (node_q.hash == cmd_hash) begin
          state_next = ST_RESP;
          if (cmd_op == OP_LOOKUP) begin
            res_ok_next = 1'b1;
            res_fc_next = FAIL_NONE;
            res_rv_next = node_q.value;
          end else if (cmd_op == OP_REMOVE) begin
            if (prev_valid) begin
              node_we = 1'b1;
              node_wa = prev;
              node_wd = '{hash: prev_hash, value: prev_val, link: node_q.link};
            end else begin
              root_we = 1'b1;
              root_wd = '{hash: root_q.hash, value: root_q.value, link: node_q.link};
            end
            if (free_top < TOP_W'(POOL_DEPTH)) begin
              stack_we      = 1'b1;
              free_top_next = free_top + TOP_W'(1);
            end
            entry_count_next = entry_count - CNT_W'(1);
            res_ok_next      = 1'b1;
            res_fc_next      = FAIL_NONE;
          end
        end else begin
          prev_valid_next = 1'b1;
          prev_next       = cur[IDX_W-1:0];
          prev_hash_next  = node_q.hash;
          prev_val_next   = node_q.value;
          cur_next        = node_q.link;
          state_next      = ST_WALK;
        end
      end
      ST_PULLRD: begin
        state_next = ST_PULL;
      end
      ST_PULL: begin
        // The first successor moves up into the root and its node is freed.
        root_we = 1'b1;
        root_wd = node_q;
        if (free_top < TOP_W'(POOL_DEPTH)) begin
          stack_we      = 1'b1;
          free_top_next = free_top + TOP_W'(1);
        end
        entry_count_next = entry_count - CNT_W'(1);
        res_ok_next      = 1'b1;
        res_fc_next      = FAIL_NONE;
        state_next       = ST_RESP;
      end
      ST_FRD: begin
        state_next = ST_FGOT;
      end
      ST_FGOT: begin
        // Stack slots below the low-water mark still hold their own index.
        node_we          = 1'b1;
        node_wa          = pop_nd;
        node_wd          = '{hash: cmd_hash, value: cmd_val, link: NO_LINK};
        new_nd_next      = pop_nd;
        free_top_next    = free_top - TOP_W'(1);
        if ({1'b0, top_m1} < min_top) begin
          min_top_next = {1'b0, top_m1};
        end
        entry_count_next = entry_count + CNT_W'(1);
        state_next       = ST_FLINK;
      end
      ST_FLINK: begin
        if (prev_valid) begin
          node_we = 1'b1;
          node_wa = prev;
          node_wd = '{hash: prev_hash, value: prev_val, link: {1'b0, new_nd}};
        end else begin
          root_we = 1'b1;
          root_wd = '{hash: root_q.hash, value: root_q.value, link: {1'b0, new_nd}};
        end
        res_ok_next = 1'b1;
        res_fc_next = FAIL_NONE;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          success_next     = res_ok;
          read_value_next  = res_rv;
          fail_code_next   = res_fc;
          entry_total_next = entry_count;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      if (cfg_data == 7'd0) begin
        bucket_count_next = 7'd1;
      end else if (cfg_data > 7'(MAX_BUCKETS)) begin
        bucket_count_next = 7'(MAX_BUCKETS);
      end else begin
        bucket_count_next = cfg_data;
      end
      root_used_next   = '0;
      free_top_next    = TOP_W'(POOL_DEPTH);
      min_top_next     = TOP_W'(POOL_DEPTH);
      entry_count_next = '0;
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    entry_count == CNT_W'($countones(root_used)) + CNT_W'(TOP_W'(POOL_DEPTH) - free_top))
    else $error("entry count disagrees with roots and pool use");

  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    min_top <= free_top)
    else $error("free stack low-water mark above stack top");

  a_resp_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP && out_valid && !out_ready) |=> state == ST_RESP)
    else $error("result item dropped while output stalled");
`endif

endmodule

### tb/sv/tb_chained_hash_table_engine_unit.sv
// Self-checking testbench for the chained hash table engine: directed table, then random keys.
`timescale 1ns / 1ps

module tb_chained_hash_table_engine_unit;
  import chte_pkg::*;

  typedef struct {
    logic        ok;
    logic [31:0] rv;
    fail_t       fc;
    logic [7:0]  total;
  } answer_t;

  typedef struct {
    op_t         op;
    logic [7:0]  ch;
    logic [31:0] val;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic signed [7:0]  key_char;
  logic signed [31:0] entry_value;
  logic               out_valid;
  logic               out_ready;
  logic               success;
  logic signed [31:0] read_value;
  logic [1:0]         fail_code;
  logic [7:0]         entry_total;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;

  chained_hash_table_engine_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .key_char(key_char), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .success(success), .read_value(read_value), .fail_code(fail_code),
    .entry_total(entry_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table.
  int unsigned    nbkt;
  bit [29:0]      hash_sum;
  bit [29:0]      hash_pow;
  bit             r_used [MAX_BUCKETS];
  bit [29:0]      r_hash [MAX_BUCKETS];
  bit [31:0]      r_val  [MAX_BUCKETS];
  bit [6:0]       r_link [MAX_BUCKETS];
  bit [29:0]      n_hash [POOL_DEPTH];
  bit [31:0]      n_val  [POOL_DEPTH];
  bit [6:0]       n_link [POOL_DEPTH];
  bit [6:0]       free_idx [POOL_DEPTH];
  int unsigned    free_cnt;
  int unsigned    stored;

  answer_t pending_results[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  full_seen = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;

  function automatic void table_clear();
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      r_used[i] = 0; r_link[i] = NO_LINK;
    end
    for (int i = 0; i < POOL_DEPTH; i++) begin
      n_link[i] = NO_LINK; free_idx[i] = 7'(i);
    end
    free_cnt = POOL_DEPTH;
    stored = 0;
  endfunction

  function automatic void bucket_setting(bit [6:0] v);
    nbkt = (v == 0) ? 1 : (v > MAX_BUCKETS) ? MAX_BUCKETS : v;
    table_clear();
  endfunction

  // Applies one item to the shadow table; returns 1 when the item yields a result.
  function automatic bit table_apply(op_t op, bit [7:0] ch, bit [31:0] val,
                                     output answer_t a);
    bit [63:0] d, t;
    bit [29:0] h;
    int unsigned b, cur, prev, steps, nd;
    a.ok = 0; a.rv = 0; a.fc = FAIL_ABSENT; a.total = 0;
    if (op == OP_CHAR) begin
      if (ch == 0) return 0;
      d = {{56{ch[7]}}, ch} - 64'd96;
      t = 64'(hash_sum) + d * 64'(hash_pow);
      hash_sum = 30'(t % 64'd1000000009);
      hash_pow = 30'((64'(hash_pow) * 64'd31) % 64'd1000000009);
      return 0;
    end
    h = hash_sum;
    hash_sum = 0;
    hash_pow = 1;
    b = (h % nbkt) % MAX_BUCKETS;
    if (!r_used[b]) begin
      if (op == OP_ADD) begin
        r_used[b] = 1; r_hash[b] = h; r_val[b] = val; r_link[b] = NO_LINK;
        stored++; a.ok = 1; a.fc = FAIL_NONE;
      end
    end else if (r_hash[b] == h) begin
      if (op == OP_LOOKUP) begin
        a.ok = 1; a.fc = FAIL_NONE; a.rv = r_val[b];
      end else if (op == OP_REMOVE) begin
        nd = r_link[b];
        // The first successor moves up into the root.
        if (nd < POOL_DEPTH) begin
          r_hash[b] = n_hash[nd]; r_val[b] = n_val[nd]; r_link[b] = n_link[nd];
          if (free_cnt < POOL_DEPTH) free_idx[free_cnt++] = 7'(nd);
        end else begin
          r_used[b] = 0;
        end
        stored--; a.ok = 1; a.fc = FAIL_NONE;
      end
    end else begin
      prev = NO_LINK;
      cur = r_link[b];
      for (steps = 0; steps < POOL_DEPTH && cur < POOL_DEPTH; steps++) begin
        if (n_hash[cur] == h) break;
        prev = cur;
        cur = n_link[cur];
      end
      if (cur < POOL_DEPTH && n_hash[cur] == h) begin
        if (op == OP_LOOKUP) begin
          a.ok = 1; a.fc = FAIL_NONE; a.rv = n_val[cur];
        end else if (op == OP_REMOVE) begin
          if (prev < POOL_DEPTH) n_link[prev] = n_link[cur];
          else r_link[b] = n_link[cur];
          if (free_cnt < POOL_DEPTH) free_idx[free_cnt++] = 7'(cur);
          stored--; a.ok = 1; a.fc = FAIL_NONE;
        end
      end else if (op == OP_ADD) begin
        if (free_cnt == 0) begin
          a.fc = FAIL_FULL;
        end else begin
          nd = free_idx[--free_cnt] % POOL_DEPTH;
          n_hash[nd] = h; n_val[nd] = val; n_link[nd] = NO_LINK;
          if (prev < POOL_DEPTH) n_link[prev] = 7'(nd);
          else r_link[b] = 7'(nd);
          stored++; a.ok = 1; a.fc = FAIL_NONE;
        end
      end
    end
    a.total = 8'(stored);
    return 1;
  endfunction

  // Offers one item, waits for acceptance, then records what it should produce.
  task automatic send_item(op_t op, bit [7:0] ch, bit [31:0] val,
                           bit typed = 0, answer_t typed_ans = '{0, 0, FAIL_NONE, 0});
    answer_t a;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    key_char    <= ch;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (table_apply(op, ch, val, a)) begin
      if (a.fc == FAIL_FULL) full_seen++;
      pending_results.push_back(typed ? typed_ans : a);
    end
  endtask

  // Bucket count may only change with the engine idle.
  task automatic write_buckets(bit [6:0] v);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bucket_setting(v);
  endtask

  bit [7:0] keys [24][$];

  task automatic send_key(int k);
    for (int i = 0; i < keys[k].size(); i++) send_item(OP_CHAR, keys[k][i], 0);
  endtask

  task automatic random_run(int n);
    int goal;
    int r;
    goal = items_sent + n;
    while (items_sent < goal) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        send_key($urandom_range(0, 23));
        r = $urandom_range(0, 9);
        send_item(r < 4 ? OP_ADD : (r < 7 ? OP_LOOKUP : OP_REMOVE), 0, $urandom());
      end else begin
        send_item(op_t'($urandom_range(0, 3)), 8'($urandom()), $urandom());
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int stall;
    answer_t e;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result success=%0b read_value=%h fail_code=%0d total=%0d",
                   $time, success, read_value, fail_code, entry_total);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (success !== e.ok || read_value !== e.rv || fail_code !== e.fc ||
              entry_total !== e.total) begin
            $display("%0t: mismatch expected %0b/%h/%0d/%0d actual %0b/%h/%0d/%0d",
                     $time, e.ok, e.rv, e.fc, e.total,
                     success, read_value, fail_code, entry_total);
            errors++;
          end
        end
      end
      if (hold_req) begin
        stall = 400;
        hold_req = 0;
      end else if (stall == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 20000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(op_t op, bit [7:0] ch, bit [31:0] val, bit typed = 0,
                              bit ok = 0, bit [31:0] rv = 0, fail_t fc = FAIL_NONE,
                              bit [7:0] tot = 0);
    row_t r;
    r.op = op; r.ch = ch; r.val = val; r.typed = typed;
    r.ans = '{ok, rv, fc, tot};
    return r;
  endfunction

  initial begin
    int len;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= OP_CHAR;
    key_char    <= 8'sd0;
    entry_value <= 32'sd0;
    cfg_valid   <= 1'b0;
    cfg_data    <= 7'd0;
    nbkt = 16; hash_sum = 0; hash_pow = 1;
    table_clear();

    for (int k = 0; k < 24; k++) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
        keys[k].push_back((k < 16) ? 8'($urandom_range(8'h61, 8'h7a))
                                   : 8'($urandom_range(1, 255)));
    end

    // With 16 buckets, the keys "b" and "r" share bucket 2.
    dir_rows.push_back(mk(OP_LOOKUP, 0, 0, 1, 0, 0, FAIL_ABSENT, 0));
    dir_rows.push_back(mk(OP_REMOVE, 0, 0, 1, 0, 0, FAIL_ABSENT, 0));
    dir_rows.push_back(mk(OP_ADD, 0, 32'h7fffffff, 1, 1, 0, FAIL_NONE, 1));
    dir_rows.push_back(mk(OP_ADD, 0, 32'h1, 1, 0, 0, FAIL_ABSENT, 1));
    dir_rows.push_back(mk(OP_LOOKUP, 0, 0, 1, 1, 32'h7fffffff, FAIL_NONE, 1));
    dir_rows.push_back(mk(OP_CHAR, 8'h00, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h80, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h7f, 0));
    dir_rows.push_back(mk(OP_ADD, 0, 32'h80000000));
    dir_rows.push_back(mk(OP_CHAR, 8'h62, 0));
    dir_rows.push_back(mk(OP_ADD, 0, 32'hffffffff));
    dir_rows.push_back(mk(OP_CHAR, 8'h72, 0));
    dir_rows.push_back(mk(OP_ADD, 0, 32'h12345678));
    dir_rows.push_back(mk(OP_CHAR, 8'h72, 0));
    dir_rows.push_back(mk(OP_LOOKUP, 0, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h62, 0));
    dir_rows.push_back(mk(OP_REMOVE, 0, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h72, 0));
    dir_rows.push_back(mk(OP_LOOKUP, 0, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h72, 0));
    dir_rows.push_back(mk(OP_REMOVE, 0, 0));
    dir_rows.push_back(mk(OP_CHAR, 8'h72, 0));
    dir_rows.push_back(mk(OP_LOOKUP, 0, 0));
    dir_rows.push_back(mk(OP_REMOVE, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].ans);

    // One bucket: every extra key goes to the pool until it runs out.
    write_buckets(7'd1);
    for (int c = 1; c <= 70; c++) begin
      send_item(OP_CHAR, 8'(c), 0);
      send_item(OP_ADD, 0, $urandom());
    end
    random_run(40);

    write_buckets(7'd64);
    random_run(60);
    hold_req = 1;
    random_run(60);
    write_buckets(7'd0);
    random_run(50);
    write_buckets(7'd127);
    random_run(50);
    write_buckets(7'd7);
    random_run(50);
    no_idle = 1;
    random_run(50);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d items and %0d results over bucket counts 16,1,64,0,127,7;",
             items_sent, results_seen);
    $display("pool-full adds: %0d, errors: %0d", full_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
